/* rtl/hrvr_pkg.sv */
// Shared constants, types and the arctangent table for the heading-relative velocity rotator.
package hrvr_pkg;

   // Field widths
   localparam int SPEED_BITS     = 15;
   localparam int TRIG_FRAC_BITS = 15;
   localparam int ANGLE_BITS     = 15;
   localparam int OUT_BITS       = 16;
   localparam int DIFF_BITS      = ANGLE_BITS + 1;

   // CORDIC datapath
   localparam int CORDIC_FRAC   = 30;
   localparam int CORDIC_ITERS  = 24;
   localparam int ITER_IDX_BITS = $clog2(CORDIC_ITERS);
   localparam int XY_BITS       = CORDIC_FRAC + 2;
   localparam int ANGLE_EXT     = 16;
   localparam int Z_BITS        = 32;

   // Trig and product words
   localparam int TRIG_BITS = TRIG_FRAC_BITS + 2;
   localparam int PROD_BITS = TRIG_BITS + SPEED_BITS;
   localparam int ACC_BITS  = PROD_BITS + 1;

   // Angles in 1/64 degree
   localparam logic signed [DIFF_BITS-1:0] HALF_TURN    = DIFF_BITS'(11520);
   localparam logic signed [DIFF_BITS-1:0] FULL_TURN    = DIFF_BITS'(23040);
   localparam logic signed [DIFF_BITS-1:0] QUARTER_TURN = DIFF_BITS'(5760);

   // CORDIC start x = gain inverse in Q.30
   localparam logic signed [XY_BITS-1:0] CORDIC_START = XY_BITS'(652032874);

   // CSR map
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_WORD_BITS = CSR_ADDR_BITS - 2;
   localparam logic [CSR_WORD_BITS-1:0] CSR_CENTRE_WORD = CSR_WORD_BITS'(0);

   // One CORDIC pipeline slot plus sideband
   typedef struct packed {
      logic signed [XY_BITS-1:0]    x;
      logic signed [XY_BITS-1:0]    y;
      logic signed [Z_BITS-1:0]     z;
      logic                         flip;
      logic signed [SPEED_BITS-1:0] sx;
      logic signed [SPEED_BITS-1:0] sy;
   } hrvr_rot_type;

   // atan(2^-i) in 1/(64*65536) degree
   function automatic logic signed [Z_BITS-1:0] hrvr_atan(input logic [ITER_IDX_BITS-1:0] idx);
      logic signed [Z_BITS-1:0] val;
      case (idx)
         5'd0:    val = Z_BITS'(188743680);
         5'd1:    val = Z_BITS'(111421900);
         5'd2:    val = Z_BITS'(58872272);
         5'd3:    val = Z_BITS'(29884485);
         5'd4:    val = Z_BITS'(15000234);
         5'd5:    val = Z_BITS'(7507429);
         5'd6:    val = Z_BITS'(3754631);
         5'd7:    val = Z_BITS'(1877430);
         5'd8:    val = Z_BITS'(938730);
         5'd9:    val = Z_BITS'(469366);
         5'd10:   val = Z_BITS'(234683);
         5'd11:   val = Z_BITS'(117342);
         5'd12:   val = Z_BITS'(58671);
         5'd13:   val = Z_BITS'(29335);
         5'd14:   val = Z_BITS'(14668);
         5'd15:   val = Z_BITS'(7334);
         5'd16:   val = Z_BITS'(3667);
         5'd17:   val = Z_BITS'(1833);
         5'd18:   val = Z_BITS'(917);
         5'd19:   val = Z_BITS'(458);
         5'd20:   val = Z_BITS'(229);
         5'd21:   val = Z_BITS'(115);
         5'd22:   val = Z_BITS'(57);
         5'd23:   val = Z_BITS'(29);
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

/* rtl/hrvr_cordic.sv */
// Rotation-mode CORDIC pipeline, one micro-rotation per register stage.
module hrvr_cordic
   import hrvr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_stall,
   input  hrvr_rot_type in_data,
   output logic         out_valid,
   input  logic         out_stall,
   output hrvr_rot_type out_data
);

   logic [CORDIC_ITERS-1:0] valid_ff;
   hrvr_rot_type            rot_ff [CORDIC_ITERS];
   logic [CORDIC_ITERS-1:0] adv;

   for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
      hrvr_rot_type             src;
      hrvr_rot_type             rot_in;
      logic                     src_valid;
      logic                     next_stall;
      logic signed [XY_BITS-1:0] dx;
      logic signed [XY_BITS-1:0] dy;

      if (i == 0) begin : g_first
         assign src       = in_data;
         assign src_valid = in_valid;
      end else begin : g_rest
         assign src       = rot_ff[i-1];
         assign src_valid = valid_ff[i-1];
      end

      if (i == CORDIC_ITERS - 1) begin : g_last
         assign next_stall = out_stall;
      end else begin : g_mid
         assign next_stall = !adv[i+1];
      end

      // a stage moves when empty or when its successor moves
      assign adv[i] = !valid_ff[i] || !next_stall;

      always_comb begin
         dx     = $signed(src.y) >>> i;
         dy     = $signed(src.x) >>> i;
         rot_in = src;
         if (!src.z[Z_BITS-1]) begin
            rot_in.x = src.x - dx;
            rot_in.y = src.y + dy;
            rot_in.z = src.z - hrvr_atan(ITER_IDX_BITS'(i));
         end else begin
            rot_in.x = src.x + dx;
            rot_in.y = src.y - dy;
            rot_in.z = src.z + hrvr_atan(ITER_IDX_BITS'(i));
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (adv[i]) begin
            valid_ff[i] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (adv[i] && src_valid) begin
            rot_ff[i] <= rot_in;
         end
      end
   end

   assign in_stall  = !adv[0];
   assign out_valid = valid_ff[CORDIC_ITERS-1];
   assign out_data  = rot_ff[CORDIC_ITERS-1];

endmodule

/* rtl/heading_relative_velocity_rotation.sv */
// Top level: yaw offset, CORDIC sin/cos, and rotation of the commanded velocity.
//
//   channel  dir  handshake             payload
//   req_     in   req_valid/req_stall   yaw_angle, speed_x, speed_y
//   rsp_     out  rsp_valid/rsp_stall   rotated_x, rotated_y
//   csr_     in   APB psel/penable      centre_angle at byte 0
//
// One transaction enters per cycle while req_stall is low. Stages in order:
// offset/fold, 24 CORDIC micro-rotation stages, trig rounding, multiply,
// round/saturate; the CORDIC pipeline does one micro-rotation per stage.
// Reset (synchronous) empties every stage and sets centre_angle to 0.
// Each stage holds while its successor is full and stalled; empty stages still
// fill, so requests keep being taken while a result waits on rsp_stall.
module heading_relative_velocity_rotation
   import hrvr_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [ANGLE_BITS-1:0]       req_yaw_angle,
   input  logic signed [SPEED_BITS-1:0] req_speed_x,
   input  logic signed [SPEED_BITS-1:0] req_speed_y,
   // response channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [OUT_BITS-1:0]  rsp_rotated_x,
   output logic signed [OUT_BITS-1:0]  rsp_rotated_y,
   // configuration
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                        csr_pready
);

   // Rounding constants
   localparam int TRIG_SHIFT = CORDIC_FRAC - TRIG_FRAC_BITS;
   localparam logic signed [XY_BITS-1:0]   TRIG_HALF = XY_BITS'(1) <<< (TRIG_SHIFT - 1);
   localparam logic signed [XY_BITS-1:0]   TRIG_LIM  = XY_BITS'(1) <<< TRIG_FRAC_BITS;
   localparam logic signed [XY_BITS-1:0]   TRIG_LIM_NEG = -TRIG_LIM;
   localparam logic signed [TRIG_BITS-1:0] TRIG_ONE  = TRIG_BITS'(1) <<< TRIG_FRAC_BITS;
   localparam logic signed [TRIG_BITS-1:0] TRIG_ONE_NEG = -TRIG_ONE;
   localparam logic signed [ACC_BITS-1:0]  OUT_HALF  = ACC_BITS'(1) <<< (TRIG_FRAC_BITS - 1);
   localparam logic signed [ACC_BITS-1:0]  OUT_MAX   = ACC_BITS'((1 << (OUT_BITS - 1)) - 1);
   localparam logic signed [ACC_BITS-1:0]  OUT_MIN   = -(ACC_BITS'(1) <<< (OUT_BITS - 1));
   localparam logic signed [Z_BITS-1:0]    Z_MAX     = Z_BITS'(QUARTER_TURN) <<< ANGLE_EXT;
   localparam logic signed [Z_BITS-1:0]    Z_MIN     = -Z_MAX;

   // Q.30 -> Q.TRIG_FRAC_BITS, round half up, clamp to +-1.0
   function automatic logic signed [TRIG_BITS-1:0] to_trig(input logic signed [XY_BITS-1:0] v);
      logic signed [XY_BITS-1:0] r;
      r = (v + TRIG_HALF) >>> TRIG_SHIFT;
      if (r > TRIG_LIM) begin
         r = TRIG_LIM;
      end else if (r < TRIG_LIM_NEG) begin
         r = TRIG_LIM_NEG;
      end
      return TRIG_BITS'(r);
   endfunction

   // Q.TRIG_FRAC_BITS sum -> integer, round half up, saturate
   function automatic logic signed [OUT_BITS-1:0] to_out(input logic signed [ACC_BITS-1:0] a);
      logic signed [ACC_BITS-1:0] r;
      r = (a + OUT_HALF) >>> TRIG_FRAC_BITS;
      if (r > OUT_MAX) begin
         r = OUT_MAX;
      end else if (r < OUT_MIN) begin
         r = OUT_MIN;
      end
      return OUT_BITS'(r);
   endfunction

   // ------------------------------------------------------------------
   // CSR
   // ------------------------------------------------------------------
   logic [ANGLE_BITS-1:0]    centre_ff;
   logic                     csr_wr;
   logic [CSR_WORD_BITS-1:0] csr_word;

   assign csr_pready = 1'b1;
   assign csr_word   = csr_paddr[CSR_ADDR_BITS-1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         centre_ff <= '0;
      end else if (csr_wr && (csr_word == CSR_CENTRE_WORD)) begin
         centre_ff <= csr_pwdata[ANGLE_BITS-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_word == CSR_CENTRE_WORD) begin
         csr_prdata = CSR_DATA_BITS'(centre_ff);
      end
   end

   // ------------------------------------------------------------------
   // Stall chain: a stage advances when empty or when the next one does
   // ------------------------------------------------------------------
   logic a_adv, t_adv, m_adv, o_adv;
   logic cordic_in_stall;
   logic cordic_valid;
   hrvr_rot_type cordic_data;

   logic a_valid_ff, t_valid_ff, m_valid_ff, rsp_valid_ff;

   assign o_adv     = !rsp_valid_ff || !rsp_stall;
   assign m_adv     = !m_valid_ff || o_adv;
   assign t_adv     = !t_valid_ff || m_adv;
   assign a_adv     = !a_valid_ff || !cordic_in_stall;
   assign req_stall = !a_adv;

   // ------------------------------------------------------------------
   // Stage A: yaw offset, single 360 wrap, fold into +-90 degrees
   // ------------------------------------------------------------------
   logic signed [DIFF_BITS-1:0] diff;
   logic signed [DIFF_BITS-1:0] wrap_d;
   logic signed [DIFF_BITS-1:0] fold_d;
   logic                        fold_flip;
   hrvr_rot_type                rot_a_in;
   hrvr_rot_type                rot_a_ff;

   always_comb begin
      diff = $signed({1'b0, req_yaw_angle}) - $signed({1'b0, centre_ff});

      if (diff > HALF_TURN) begin
         wrap_d = diff - FULL_TURN;
      end else if (diff < -HALF_TURN) begin
         wrap_d = diff + FULL_TURN;
      end else begin
         wrap_d = diff;
      end

      // beyond +-90 degrees: rotate by 180 and negate sin/cos later
      fold_flip = 1'b0;
      if (wrap_d > QUARTER_TURN) begin
         fold_d    = wrap_d - HALF_TURN;
         fold_flip = 1'b1;
      end else if (wrap_d < -QUARTER_TURN) begin
         fold_d    = wrap_d + HALF_TURN;
         fold_flip = 1'b1;
      end else begin
         fold_d = wrap_d;
      end

      rot_a_in.x    = CORDIC_START;
      rot_a_in.y    = '0;
      rot_a_in.z    = Z_BITS'(fold_d) <<< ANGLE_EXT;
      rot_a_in.flip = fold_flip;
      rot_a_in.sx   = req_speed_x;
      rot_a_in.sy   = req_speed_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_adv) begin
         a_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (a_adv && req_valid) begin
         rot_a_ff <= rot_a_in;
      end
   end

   // ------------------------------------------------------------------
   // CORDIC micro-rotations
   // ------------------------------------------------------------------
   hrvr_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (a_valid_ff),
      .in_stall  (cordic_in_stall),
      .in_data   (rot_a_ff),
      .out_valid (cordic_valid),
      .out_stall (!t_adv),
      .out_data  (cordic_data)
   );

   // ------------------------------------------------------------------
   // Stage T: round cos/sin, undo the fold
   // ------------------------------------------------------------------
   logic signed [TRIG_BITS-1:0]  cos_rnd, sin_rnd;
   logic signed [TRIG_BITS-1:0]  cos_in, sin_in;
   logic signed [TRIG_BITS-1:0]  cos_ff, sin_ff;
   logic signed [SPEED_BITS-1:0] t_sx_ff, t_sy_ff;

   always_comb begin
      cos_rnd = to_trig(cordic_data.x);
      sin_rnd = to_trig(cordic_data.y);
      cos_in  = cordic_data.flip ? -cos_rnd : cos_rnd;
      sin_in  = cordic_data.flip ? -sin_rnd : sin_rnd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t_valid_ff <= 1'b0;
      end else if (t_adv) begin
         t_valid_ff <= cordic_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (t_adv && cordic_valid) begin
         cos_ff  <= cos_in;
         sin_ff  <= sin_in;
         t_sx_ff <= cordic_data.sx;
         t_sy_ff <= cordic_data.sy;
      end
   end

   // ------------------------------------------------------------------
   // Stage M: four products
   // ------------------------------------------------------------------
   logic signed [PROD_BITS-1:0] p_cx_in, p_sy_in, p_sx_in, p_cy_in;
   logic signed [PROD_BITS-1:0] p_cx_ff, p_sy_ff, p_sx_ff, p_cy_ff;

   assign p_cx_in = PROD_BITS'(cos_ff) * PROD_BITS'(t_sx_ff);
   assign p_sy_in = PROD_BITS'(sin_ff) * PROD_BITS'(t_sy_ff);
   assign p_sx_in = PROD_BITS'(sin_ff) * PROD_BITS'(t_sx_ff);
   assign p_cy_in = PROD_BITS'(cos_ff) * PROD_BITS'(t_sy_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (m_adv) begin
         m_valid_ff <= t_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (m_adv && t_valid_ff) begin
         p_cx_ff <= p_cx_in;
         p_sy_ff <= p_sy_in;
         p_sx_ff <= p_sx_in;
         p_cy_ff <= p_cy_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage O: sum, round to nearest, saturate; output register
   // ------------------------------------------------------------------
   logic signed [OUT_BITS-1:0] rot_x_in, rot_y_in;
   logic signed [OUT_BITS-1:0] rot_x_ff, rot_y_ff;

   assign rot_x_in = to_out(ACC_BITS'(p_cx_ff) - ACC_BITS'(p_sy_ff));
   assign rot_y_in = to_out(ACC_BITS'(p_sx_ff) + ACC_BITS'(p_cy_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (o_adv) begin
         rsp_valid_ff <= m_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (o_adv && m_valid_ff) begin
         rot_x_ff <= rot_x_in;
         rot_y_ff <= rot_y_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_rotated_x = rot_x_ff;
   assign rsp_rotated_y = rot_y_ff;

`ifndef ASSERT_OFF
   // folded CORDIC angle stays within +-90 degrees
   a_fold_range: assert property (@(posedge clock) disable iff (reset)
      a_valid_ff |-> (rot_a_ff.z <= Z_MAX) && (rot_a_ff.z >= Z_MIN))
      else $error("folded angle out of range");

   // rounded trig values never exceed unity
   a_trig_range: assert property (@(posedge clock) disable iff (reset)
      t_valid_ff |-> (cos_ff <= TRIG_ONE) && (cos_ff >= TRIG_ONE_NEG)
                  && (sin_ff <= TRIG_ONE) && (sin_ff >= TRIG_ONE_NEG))
      else $error("trig value beyond unity");

   // a blocked product stage keeps its transaction
   a_mult_hold: assert property (@(posedge clock) disable iff (reset)
      (m_valid_ff && !o_adv) |=> m_valid_ff && $stable(p_cx_ff) && $stable(p_sy_ff))
      else $error("product stage lost data under stall");

   // a product moving on always lands in the output register
   a_out_load: assert property (@(posedge clock) disable iff (reset)
      (m_valid_ff && o_adv) |=> rsp_valid_ff)
      else $error("transaction dropped at output");
`endif

endmodule

/* sim/tb_top.sv */
// Testbench for heading_relative_velocity_rotation: self-checking, randomized, APB-configured.
`timescale 1ns / 1ps

module tb_top;
   import hrvr_pkg::*;

   // ------------------------------------------------------------------
   // Run constants
   // ------------------------------------------------------------------
   localparam int WATCHDOG_LIMIT   = 2000;  // cycles with no transaction on either channel
   localparam int SETTLE_CYCLES    = 40;    // pipeline is 28 deep, plus margin
   localparam int LONG_HOLD_CYCLES = 200;   // receiver back-pressure stretch

   localparam logic signed [SPEED_BITS-1:0] SPEED_MAX = SPEED_BITS'(16383);
   localparam logic signed [SPEED_BITS-1:0] SPEED_MIN = SPEED_BITS'(-16384);
   localparam int YAW_TOP       = 23039;   // last angle below 360 deg
   localparam int YAW_FIELD_TOP = 32767;   // largest 15-bit angle

   localparam logic [CSR_ADDR_BITS-1:0] CENTRE_REG_ADDR = {CSR_CENTRE_WORD, 2'b00};
   localparam logic [CSR_ADDR_BITS-1:0] UNUSED_REG_ADDR = CSR_ADDR_BITS'(4);

   // Angles in 1/64 deg for the predictor
   localparam longint DEG90  = 5760;
   localparam longint DEG180 = 11520;
   localparam longint DEG360 = 23040;

   // Micro-rotation datapath: Q.30, gain-compensated start vector
   localparam longint GAIN_INV_Q30 = 652032874;
   localparam longint TRIG_ONE     = longint'(1) <<< TRIG_FRAC_BITS;
   localparam longint OUT_HI       = 32767;
   localparam longint OUT_LO       = -32768;

   // atan(2^-k) in 1/(64*65536) deg
   localparam longint ARCTAN_STEP [CORDIC_ITERS] = '{
      188743680, 111421900, 58872272, 29884485, 15000234, 7507429,
      3754631, 1877430, 938730, 469366, 234683, 117342,
      58671, 29335, 14668, 7334, 3667, 1833,
      917, 458, 229, 115, 57, 29
   };

   // Directed yaw probes: quarter-turn fold edges, half-turn wrap edges, top of field
   localparam int ZERO_CENTRE_PROBES [9] = '{0, 5760, 5761, 11520, 11521,
                                             17279, 17280, 23039, 32767};
   // Same edges seen from the top centre: negative offsets and the one-step wrap
   localparam int HIGH_CENTRE_PROBES [5] = '{0, 11518, 11519, 17279, 17278};

   // ------------------------------------------------------------------
   // Scoreboard: rotation predictor plus FIFO of pending rotated vectors
   // ------------------------------------------------------------------
   class rotation_scoreboard;
      typedef struct {
         logic signed [OUT_BITS-1:0] rot_x;
         logic signed [OUT_BITS-1:0] rot_y;
         int                         seq;
      } rotated_vec_type;

      rotated_vec_type       pending_q[$];
      logic [ANGLE_BITS-1:0] centre     = '0;
      int                    mismatches = 0;
      int                    n_requests = 0;
      int                    n_results  = 0;
      int                    n_folded   = 0;
      int                    n_wrapped  = 0;
      int                    n_settings = 0;

      task report_mismatch(input string msg);
         mismatches++;
         $display("[%0t] mismatch: %s", $time, msg);
      endtask

      // Q.30 -> Q.TRIG_FRAC_BITS, add half and floor, clamp to +-1.0
      function longint round_trig(input longint v);
         longint r;
         r = (v + (longint'(1) <<< (CORDIC_FRAC - TRIG_FRAC_BITS - 1)))
             >>> (CORDIC_FRAC - TRIG_FRAC_BITS);
         if (r > TRIG_ONE) r = TRIG_ONE;
         if (r < -TRIG_ONE) r = -TRIG_ONE;
         return r;
      endfunction

      // Q.TRIG_FRAC_BITS sum -> integer, add half and floor, saturate
      function logic signed [OUT_BITS-1:0] round_out(input longint acc);
         longint r;
         r = (acc + (longint'(1) <<< (TRIG_FRAC_BITS - 1))) >>> TRIG_FRAC_BITS;
         if (r > OUT_HI) r = OUT_HI;
         if (r < OUT_LO) r = OUT_LO;
         return OUT_BITS'(r);
      endfunction

      function void rotate_velocity(input logic [ANGLE_BITS-1:0] yaw,
                                    input logic signed [SPEED_BITS-1:0] vx,
                                    input logic signed [SPEED_BITS-1:0] vy,
                                    output logic signed [OUT_BITS-1:0] rx,
                                    output logic signed [OUT_BITS-1:0] ry);
         longint offset, ax, ay, z, step_x, step_y, cos_q, sin_q;
         bit     folded;
         int     k;
         offset = longint'(yaw) - longint'(centre);
         // single wrap into +-180 deg
         if (offset > DEG180) begin
            offset -= DEG360;
            n_wrapped++;
         end else if (offset < -DEG180) begin
            offset += DEG360;
            n_wrapped++;
         end
         // fold into +-90 deg, negate trig afterwards
         folded = 1'b0;
         if (offset > DEG90) begin
            offset -= DEG180;
            folded = 1'b1;
         end else if (offset < -DEG90) begin
            offset += DEG180;
            folded = 1'b1;
         end
         if (folded) n_folded++;
         z  = offset <<< 16;
         ax = GAIN_INV_Q30;
         ay = 0;
         for (k = 0; k < CORDIC_ITERS; k++) begin
            step_x = ay >>> k;
            step_y = ax >>> k;
            if (z >= 0) begin
               ax -= step_x;
               ay += step_y;
               z  -= ARCTAN_STEP[k];
            end else begin
               ax += step_x;
               ay -= step_y;
               z  += ARCTAN_STEP[k];
            end
         end
         cos_q = round_trig(ax);
         sin_q = round_trig(ay);
         if (folded) begin
            cos_q = -cos_q;
            sin_q = -sin_q;
         end
         rx = round_out(cos_q * longint'(vx) - sin_q * longint'(vy));
         ry = round_out(sin_q * longint'(vx) + cos_q * longint'(vy));
      endfunction

      function void note_request(input logic [ANGLE_BITS-1:0] yaw,
                                 input logic signed [SPEED_BITS-1:0] vx,
                                 input logic signed [SPEED_BITS-1:0] vy);
         rotated_vec_type v;
         rotate_velocity(yaw, vx, vy, v.rot_x, v.rot_y);
         v.seq = n_requests;
         n_requests++;
         pending_q.push_back(v);
      endfunction

      task check_result(input logic signed [OUT_BITS-1:0] rx,
                        input logic signed [OUT_BITS-1:0] ry);
         rotated_vec_type v;
         n_results++;
         if (pending_q.size() == 0) begin
            report_mismatch($sformatf("result (%0d,%0d) with no transaction pending", rx, ry));
         end else begin
            v = pending_q.pop_front();
            if (rx !== v.rot_x)
               report_mismatch($sformatf("#%0d rotated_x got %0d want %0d", v.seq, rx, v.rot_x));
            if (ry !== v.rot_y)
               report_mismatch($sformatf("#%0d rotated_y got %0d want %0d", v.seq, ry, v.rot_y));
         end
      endtask

      function int pending();
         return pending_q.size();
      endfunction
   endclass

   // ------------------------------------------------------------------
   // DUT signals and instance
   // ------------------------------------------------------------------
   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   logic [ANGLE_BITS-1:0]        req_yaw_angle;
   logic signed [SPEED_BITS-1:0] req_speed_x;
   logic signed [SPEED_BITS-1:0] req_speed_y;
   logic                         rsp_valid;
   logic                         rsp_stall;
   logic signed [OUT_BITS-1:0]   rsp_rotated_x;
   logic signed [OUT_BITS-1:0]   rsp_rotated_y;
   logic                         csr_psel;
   logic                         csr_penable;
   logic                         csr_pwrite;
   logic [CSR_ADDR_BITS-1:0]     csr_paddr;
   logic [CSR_DATA_BITS-1:0]     csr_pwdata;
   logic [CSR_DATA_BITS-1:0]     csr_prdata;
   logic                         csr_pready;

   heading_relative_velocity_rotation u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_yaw_angle (req_yaw_angle),
      .req_speed_x   (req_speed_x),
      .req_speed_y   (req_speed_y),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_rotated_x (rsp_rotated_x),
      .rsp_rotated_y (rsp_rotated_y),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready)
   );

   rotation_scoreboard sb = new();

   bit req_idling_on     = 1'b1;  // random gaps between sent transactions
   bit rsp_idling_on     = 1'b1;  // random stall bursts on the result side
   bit long_hold_pending = 1'b0;  // ask the receiver for one long hold
   int quiet_cycles      = 0;

   // 2 ns clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Monitors: both channels sampled at the rising edge
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_request(req_yaw_angle, req_speed_x, req_speed_y);
         if (rsp_valid && !rsp_stall)
            sb.check_result(rsp_rotated_x, rsp_rotated_y);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Watchdog: too long with no transaction anywhere means a hang
   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("[%0t] watchdog: %0d quiet cycles, %0d results outstanding",
               $time, quiet_cycles, sb.pending());
      $display("FAIL");
      $finish;
   end

   // ------------------------------------------------------------------
   // Result-side stall generator. Changes only at the falling edge.
   // A long hold is counted here so the sender keeps pushing meanwhile.
   // ------------------------------------------------------------------
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_pending) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
            long_hold_pending = 1'b0;
            rsp_stall <= 1'b0;
         end else if (rsp_idling_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 8)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Request driver. Entered and left at a falling edge; req_valid stays
   // high across back-to-back transactions.
   // ------------------------------------------------------------------
   task automatic send_item(input logic [ANGLE_BITS-1:0] yaw,
                            input logic signed [SPEED_BITS-1:0] vx,
                            input logic signed [SPEED_BITS-1:0] vy);
      if (req_idling_on && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_yaw_angle <= yaw;
      req_speed_x   <= vx;
      req_speed_y   <= vy;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // mostly random over the full 15-bit range, some extremes; every bit toggles over the run
   function automatic logic signed [SPEED_BITS-1:0] pick_speed();
      case ($urandom_range(0, 11))
         0:       return SPEED_MAX;
         1:       return SPEED_MIN;
         2:       return '0;
         3:       return '1;
         default: return SPEED_BITS'($urandom_range(0, YAW_FIELD_TOP));
      endcase
   endfunction

   // angles past 360 deg are legal and act modulo 360
   function automatic logic [ANGLE_BITS-1:0] pick_yaw();
      if ($urandom_range(0, 7) == 0)
         return ANGLE_BITS'($urandom_range(0, YAW_FIELD_TOP));
      return ANGLE_BITS'($urandom_range(0, YAW_TOP));
   endfunction

   task automatic send_random(input int count);
      int n;
      for (n = 0; n < count; n++)
         send_item(pick_yaw(), pick_speed(), pick_speed());
   endtask

   // Drop valid and wait until every rotated vector is back, then settle
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // ------------------------------------------------------------------
   // APB access: setup cycle then access cycle, entered at a falling edge
   // ------------------------------------------------------------------
   task automatic csr_write(input logic [CSR_ADDR_BITS-1:0] addr,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      // writes beyond the centre register fall on the floor
      if (addr == CENTRE_REG_ADDR) begin
         sb.centre = data[ANGLE_BITS-1:0];
         sb.n_settings++;
      end
   endtask

   task automatic csr_read(input logic [CSR_ADDR_BITS-1:0] addr,
                           output logic [CSR_DATA_BITS-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= addr;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      data = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic check_centre_readback();
      logic [CSR_DATA_BITS-1:0] word;
      csr_read(CENTRE_REG_ADDR, word);
      if (word !== CSR_DATA_BITS'(sb.centre))
         sb.report_mismatch($sformatf("centre_angle reads %0d, expected %0d", word, sb.centre));
   endtask

   task automatic set_centre(input logic [CSR_DATA_BITS-1:0] value);
      csr_write(CENTRE_REG_ADDR, value);
      check_centre_readback();
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      int k;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_yaw_angle = '0;
      req_speed_x   = '0;
      req_speed_y   = '0;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset value of the centre register
      check_centre_readback();

      // Centre 0: speed extremes at zero offset, then the fold/wrap edges
      set_centre(0);
      send_item(0, SPEED_MAX, 0);
      send_item(0, SPEED_MIN, 0);
      send_item(0, 0, SPEED_MAX);
      send_item(0, 0, SPEED_MIN);
      send_item(0, SPEED_MAX, SPEED_MAX);
      send_item(0, SPEED_MIN, SPEED_MIN);
      send_item(0, SPEED_BITS'(-1), SPEED_BITS'(-1));
      send_item(0, 0, 0);
      for (k = 0; k < $size(ZERO_CENTRE_PROBES); k++)
         send_item(ANGLE_BITS'(ZERO_CENTRE_PROBES[k]), SPEED_MAX, SPEED_MIN);
      send_random(100);
      drain();

      // Top centre: negative offsets, wrap by a full turn
      set_centre(YAW_TOP);
      for (k = 0; k < $size(HIGH_CENTRE_PROBES); k++)
         send_item(ANGLE_BITS'(HIGH_CENTRE_PROBES[k]), SPEED_MIN, SPEED_MAX);
      send_random(100);
      drain();

      // Back-pressure: receiver holds for a long stretch while requests keep
      // coming, so the pipe fills and req_stall rises
      set_centre(11520);
      long_hold_pending = 1'b1;
      send_random(90);
      drain();

      // Unmapped register must not disturb the centre; then a write with all
      // data bits set lands as the 15-bit maximum
      csr_write(UNUSED_REG_ADDR, $urandom());
      check_centre_readback();
      set_centre({CSR_DATA_BITS{1'b1}});
      send_random(70);
      drain();

      // Random centre; pause mid-stream until everything is back
      set_centre($urandom_range(0, YAW_TOP));
      send_random(60);
      drain();
      send_random(60);
      drain();

      // Last stretch at full rate on both sides
      set_centre($urandom_range(0, YAW_FIELD_TOP));
      req_idling_on = 1'b0;
      rsp_idling_on = 1'b0;
      send_random(60);
      drain();

      $display("Covered %0d transactions (%0d results) over %0d centre settings;",
               sb.n_requests, sb.n_results, sb.n_settings);
      $display("  %0d offsets folded past 90 deg, %0d wrapped at 180 deg, %0d mismatches.",
               sb.n_folded, sb.n_wrapped, sb.mismatches);
      if (sb.mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
